FILE: rtl/pcd_pkg.sv
// Shared types and constants for the PCM channel downmix block.
package pcd_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int SAMPLE_W     = 32;
	localparam int SUM_W        = SAMPLE_W + $clog2(MAX_CHANNELS);
	localparam int CNT_W        = $clog2(MAX_CHANNELS);
	localparam int CHAN_W       = 4;
	localparam int DIV_STEPS    = SUM_W;
	localparam int STEP_W       = $clog2(DIV_STEPS + 1);
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;
	localparam int REG_IDX_W    = 2;

	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_CHANNELS  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEST_CHANNELS = 2'd2;

	localparam logic [1:0] FMT_16 = 2'd0;
	localparam logic [1:0] FMT_24 = 2'd1;

	typedef struct packed {
		logic [1:0]        sample_format;
		logic [CHAN_W-1:0] in_chans;
		logic [CHAN_W-1:0] out_chans;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       block_end;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       run_last;
		logic                       bad_layout;
		logic                       buffer_end;
	} out_word_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [CHAN_W-1:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [SUM_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SEND_A,
		ST_SEND_B
	} state_t;

endpackage

FILE: rtl/pcm_channel_downmix.sv
// Top level of the PCM channel downmix block.
// Usage:
//   Input channel: one interleaved signed sample per word (src_valid, src_stall,
//   src_word), sign-extended from the width in sample_format. Output channel:
//   result words (dst_valid, dst_stall, dst_word), the last one of an input
//   flagged by run_last. Configuration goes over the APB port, at byte
//   addresses 0, 4 and 8; write it only while the block is idle, and each write
//   drops any partial frame.
//   A sample that does not close a frame is taken and the block is ready again
//   in the next cycle. A mono sample, a sample that closes a stereo pair
//   (halved by a shift) and a sample under an unsupported pairing load their
//   words from the next cycle on, and the next sample is taken only once they
//   are loaded. A sample that closes any other frame starts the serial
//   divider, one quotient bit a cycle; the quotient is then taken and both
//   words are loaded before the next sample is taken.
//   src_stall is high while a frame is divided or results are handed off.
//   dst_word sits in an output register; while dst_stall is high it holds a
//   valid word and the sequencer waits to load the next one.
//   Reset clears the frame sum and count and sets 16-bit, two to two.
module pcm_channel_downmix (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       src_valid,
	output logic                       src_stall,
	input  pcd_pkg::in_word_t          src_word,
	output logic                       dst_valid,
	input  logic                       dst_stall,
	output pcd_pkg::out_word_t         dst_word,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pcd_pkg::ADDR_W-1:0] paddr,
	input  logic [pcd_pkg::DATA_W-1:0] pwdata,
	output logic [pcd_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import pcd_pkg::*;

	cfg_t      cfg;
	logic      cfg_wr;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	state_t    state_q, state_d;

	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SAMPLE_W-1:0]     val_q;
	logic                    bad_q;
	logic                    end_q;
	logic                    two_q;
	logic                    dvalid_q;
	out_word_t               dword_q;

	logic                    accept;
	logic signed [SUM_W-1:0] s_wide;
	logic signed [SUM_W-1:0] new_sum;
	logic signed [SUM_W-1:0] half_sum;
	logic [CNT_W:0]          new_cnt;
	logic                    src_ok;
	logic                    mono_up;
	logic                    pair_avg;
	logic                    frame_avg;
	logic                    bad;
	logic [CHAN_W-1:0]       target;
	logic                    frame_done;
	logic                    out_free;
	logic                    push;
	out_word_t               push_word;

	pcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	pcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept = src_valid && !src_stall;

	always_comb begin
		unique case (cfg.sample_format)
			FMT_16:  s_wide = SUM_W'($signed(src_word.sample_in[15:0]));
			FMT_24:  s_wide = SUM_W'($signed(src_word.sample_in[23:0]));
			default: s_wide = SUM_W'(src_word.sample_in);
		endcase
	end

	assign src_ok     = (cfg.in_chans >= CHAN_W'(1))
	                 && (32'(cfg.in_chans) <= MAX_CHANNELS);
	assign mono_up    = src_ok && cfg.in_chans == CHAN_W'(1)
	                 && cfg.out_chans == CHAN_W'(2);
	assign pair_avg   = src_ok && cfg.in_chans == CHAN_W'(2)
	                 && cfg.out_chans == CHAN_W'(1);
	assign frame_avg  = src_ok && !mono_up && cfg.out_chans == CHAN_W'(2);
	assign bad        = !mono_up && !pair_avg && !frame_avg;
	assign target     = pair_avg ? CHAN_W'(2) : cfg.in_chans;
	assign new_sum    = sum_q + s_wide;
	// add one to a negative sum so the shift truncates toward zero
	assign half_sum   = $signed(new_sum + {{(SUM_W-1){1'b0}}, new_sum[SUM_W-1]}) >>> 1;
	assign new_cnt    = {1'b0, cnt_q} + 1'b1;
	assign frame_done = (CHAN_W'(new_cnt) >= target);

	assign div_req.start    = accept && frame_avg && frame_done;
	assign div_req.dividend = new_sum;
	assign div_req.divisor  = target;

	assign out_free = !dvalid_q || !dst_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (mono_up)        state_d = ST_SEND_A;
					else if (bad)                state_d = ST_SEND_B;
					else if (frame_done && pair_avg) state_d = ST_SEND_B;
					else if (frame_done)         state_d = ST_DIVIDE;
					else                         state_d = ST_IDLE;
				end
			end
			ST_DIVIDE: begin
				if (div_rsp.done) state_d = two_q ? ST_SEND_A : ST_SEND_B;
			end
			ST_SEND_A: begin
				if (out_free) state_d = ST_SEND_B;
			end
			ST_SEND_B: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		src_stall            = (state_q != ST_IDLE);
		push                 = 1'b0;
		push_word.sample_out = $signed(val_q);
		push_word.run_last   = (state_q == ST_SEND_B);
		push_word.bad_layout = bad_q;
		push_word.buffer_end = end_q;
		unique case (state_q)
			ST_SEND_A, ST_SEND_B: push = out_free;
			default:              push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sum_q    <= '0;
			cnt_q    <= '0;
			dvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push)          dvalid_q <= 1'b1;
			else if (!dst_stall) dvalid_q <= 1'b0;
			if (cfg_wr) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else if (accept) begin
				// a closed frame, a block end, a pass-through or an unsupported layout drops the frame state
				if (mono_up || bad || frame_done || src_word.block_end) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= new_sum;
					cnt_q <= new_cnt[CNT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (mono_up)       val_q <= SAMPLE_W'(s_wide);
			else if (pair_avg) val_q <= SAMPLE_W'(half_sum);
			else               val_q <= '0;
			bad_q <= bad;
			two_q <= mono_up || frame_avg;
			end_q <= src_word.block_end;
		end else if (state_q == ST_DIVIDE && div_rsp.done) begin
			val_q <= SAMPLE_W'(div_rsp.quotient);
		end
		if (push) dword_q <= push_word;
	end

	assign dst_valid = dvalid_q;
	assign dst_word  = dword_q;

endmodule

FILE: rtl/pcd_regs.sv
// APB configuration registers of the downmix block.
module pcd_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pcd_pkg::ADDR_W-1:0] paddr,
	input  logic [pcd_pkg::DATA_W-1:0] pwdata,
	output logic [pcd_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output pcd_pkg::cfg_t              cfg,
	output logic                       cfg_wr
);
	import pcd_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_format <= FMT_16;
			cfg_q.in_chans      <= CHAN_W'(2);
			cfg_q.out_chans     <= CHAN_W'(2);
		end else if (wr_en) begin
			unique case (idx)
				REG_SAMPLE_FORMAT: cfg_q.sample_format <= pwdata[1:0];
				REG_SRC_CHANNELS:  cfg_q.in_chans      <= pwdata[CHAN_W-1:0];
				REG_DEST_CHANNELS: cfg_q.out_chans     <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// writes past the register list leave the frame alone
	always_comb begin
		unique case (idx)
			REG_SAMPLE_FORMAT,
			REG_SRC_CHANNELS,
			REG_DEST_CHANNELS: cfg_wr = wr_en;
			default:           cfg_wr = 1'b0;
		endcase
	end

	always_comb begin
		unique case (idx)
			REG_SAMPLE_FORMAT: prdata = DATA_W'(cfg_q.sample_format);
			REG_SRC_CHANNELS:  prdata = DATA_W'(cfg_q.in_chans);
			REG_DEST_CHANNELS: prdata = DATA_W'(cfg_q.out_chans);
			default:           prdata = '0;
		endcase
	end

endmodule

FILE: rtl/pcd_div.sv
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
module pcd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pcd_pkg::div_req_t req,
	output pcd_pkg::div_rsp_t rsp
);
	import pcd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CHAN_W-1:0] rem_q;
	logic [CHAN_W-1:0] div_q;
	logic [CHAN_W:0]   trial;
	logic [CHAN_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[SUM_W-1];
			quo_q <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, take the quotient bit in at the low end
			rem_q <= fits ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: rtl/pcd_checker.sv
// Port-level checks for the downmix block, bound to the top level.
module pcd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               src_valid,
	input logic               src_stall,
	input pcd_pkg::in_word_t  src_word,
	input logic               dst_valid,
	input logic               dst_stall,
	input pcd_pkg::out_word_t dst_word
);
	import pcd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_word))
		else $error("result word changed while stalled");

	a_bad_word: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_word.bad_layout |-> dst_word.run_last && dst_word.sample_out == 0)
		else $error("error word not a single zero word");

	a_pair_follow: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_word.run_last && !dst_stall |=> dst_valid && dst_word.run_last)
		else $error("second word of a pair missing");

	a_busy_pair: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_word.run_last |-> src_stall)
		else $error("input taken while a pair is incomplete");

endmodule

bind pcm_channel_downmix pcd_checker u_pcd_checker (.*);

FILE: tb/sv/tb_pcm_channel_downmix.sv
// Self-checking testbench for the PCM channel downmix block.
module tb_pcm_channel_downmix;
	timeunit 1ns;
	timeprecision 1ps;

	import pcd_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [1:0] FMT_32     = 2'd2;
	localparam logic [1:0] FMT_SPARE  = 2'd3;
	localparam int SETTLE_CYCLES = 60;
	localparam int LONG_HOLD     = 300;
	localparam int RUN_LIMIT     = 1000000;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_WORDS   = 86;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_stall;
	in_word_t           src_word = '0;
	logic               dst_valid;
	logic               dst_stall = 1'b0;
	out_word_t          dst_word;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	// shadow of the block's registers and frame state
	logic [1:0]         cfg_fmt = FMT_16;
	logic [CHAN_W-1:0]  cfg_src = 4'd2;
	logic [CHAN_W-1:0]  cfg_dest = 4'd2;
	longint             frame_sum = 0;
	int                 frame_fill = 0;

	out_word_t          downmix_due[$];
	out_word_t          due_word;
	int                 fails = 0;
	int unsigned        cycle_count = 0;

	bit                 src_calm = 1'b0;
	bit                 rx_calm = 1'b0;
	logic               hold_go = 1'b0;
	int                 hold_left = 0;
	int                 stall_left = 0;
	int                 rx_gap;

	pcm_channel_downmix u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_word  (dst_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb_pcm_channel_downmix NOT OK");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 15))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			4: return ($urandom & 32'hFFFF_0000) | 32'h0000_7FFF;
			5: return ($urandom & 32'hFFFF_0000) | 32'h0000_8000;
			6: return ($urandom & 32'hFF00_0000) | 32'h007F_FFFF;
			7: return ($urandom & 32'hFF00_0000) | 32'h0080_0000;
			8: return $urandom_range(0, 15) - 8;
			default: return $urandom;
		endcase
	endfunction

	function automatic longint widen_sample(logic [31:0] raw);
		case (cfg_fmt)
			FMT_16: return longint'($signed(raw[15:0]));
			FMT_24: return longint'($signed(raw[23:0]));
			default: return longint'($signed(raw));
		endcase
	endfunction

	function automatic void push_word(longint value, bit last, bit bad, bit fin);
		out_word_t o;
		o.sample_out = value[31:0];
		o.run_last   = last;
		o.bad_layout = bad;
		o.buffer_end = fin;
		downmix_due.push_back(o);
	endfunction

	function automatic void clear_frame();
		frame_sum  = 0;
		frame_fill = 0;
	endfunction

	// work out the words one accepted sample causes
	function automatic void downmix_sample(in_word_t w);
		longint s;
		longint q;
		bit src_ok;
		s = widen_sample(w.sample_in);
		src_ok = cfg_src >= 1 && cfg_src <= MAX_CHANNELS;
		if (src_ok && cfg_src == 1 && cfg_dest == 2) begin
			clear_frame();
			push_word(s, 1'b0, 1'b0, w.block_end);
			push_word(s, 1'b1, 1'b0, w.block_end);
		end else if (src_ok && cfg_src == 2 && cfg_dest == 1) begin
			frame_sum += s;
			frame_fill++;
			if (frame_fill >= 2) begin
				q = frame_sum / 2;
				clear_frame();
				push_word(q, 1'b1, 1'b0, w.block_end);
			end else if (w.block_end) begin
				clear_frame();
			end
		end else if (src_ok && cfg_dest == 2) begin
			frame_sum += s;
			frame_fill++;
			if (frame_fill >= cfg_src) begin
				q = frame_sum / longint'(cfg_src);
				clear_frame();
				push_word(q, 1'b0, 1'b0, w.block_end);
				push_word(q, 1'b1, 1'b0, w.block_end);
			end else if (w.block_end) begin
				clear_frame();
			end
		end else begin
			clear_frame();
			push_word(0, 1'b1, 1'b1, w.block_end);
		end
	endfunction

	function automatic int frame_len();
		if (cfg_src >= 1 && cfg_src <= MAX_CHANNELS &&
		    (cfg_dest == 2 || (cfg_src == 2 && cfg_dest == 1)))
			return int'(cfg_src);
		return 1;
	endfunction

	task automatic send_word(input logic [31:0] smp, input logic fin);
		in_word_t w;
		int gap;
		w.sample_in = smp;
		w.block_end = fin;
		gap = src_calm ? 0 : pick_gap();
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_word  <= w;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		downmix_sample(w);
	endtask

	// drop valid, drain every due word, then let an unfinished frame settle
	task automatic wait_idle();
		src_valid <= 1'b0;
		@(posedge clk);
		while (downmix_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_SAMPLE_FORMAT: begin
				cfg_fmt = value[1:0];
				clear_frame();
			end
			REG_SRC_CHANNELS: begin
				cfg_src = value[CHAN_W-1:0];
				clear_frame();
			end
			REG_DEST_CHANNELS: begin
				cfg_dest = value[CHAN_W-1:0];
				clear_frame();
			end
			default: ;
		endcase
	endtask

	task automatic set_layout(input logic [1:0] fmt, input int src, input int dest);
		wait_idle();
		apb_write(REG_SAMPLE_FORMAT, DATA_W'(fmt));
		apb_write(REG_SRC_CHANNELS, src);
		apb_write(REG_DEST_CHANNELS, dest);
	endtask

	// reset layout: 16-bit, two to two; upper bits above 16 are junk
	task automatic test_reset_layout();
		send_word(32'hA5A5_7FFF, 1'b0);
		send_word(32'h1234_8000, 1'b1);
	endtask

	task automatic test_mono_to_stereo();
		set_layout(FMT_32, 1, 2);
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'h8000_0000, 1'b1);
	endtask

	// a lone sample carrying the block end is dropped with its partial frame
	task automatic test_stereo_to_mono();
		set_layout(FMT_24, 2, 1);
		send_word(32'h0012_3456, 1'b1);
		send_word(32'hAB7F_FFFF, 1'b0);
		send_word(32'h0080_0000, 1'b1);
	endtask

	task automatic test_widest_frame();
		int k;
		set_layout(FMT_32, MAX_CHANNELS, 2);
		for (k = 0; k < MAX_CHANNELS; k++)
			send_word(32'h8000_0000, k == MAX_CHANNELS - 1);
	endtask

	task automatic test_unsupported();
		set_layout(FMT_16, 0, 2);
		send_word(32'h0000_1234, 1'b1);
		set_layout(FMT_24, 15, 2);
		send_word(32'hFFFF_FFFF, 1'b0);
		set_layout(FMT_SPARE, 9, 2);
		send_word(32'h8000_0000, 1'b1);
		set_layout(FMT_32, 1, 1);
		send_word(32'h7FFF_FFFF, 1'b0);
		set_layout(FMT_16, 2, 0);
		send_word(32'h0000_8000, 1'b1);
		set_layout(FMT_32, 3, 15);
		send_word(32'h0000_0001, 1'b0);
	endtask

	// an unmapped write keeps a partial frame, a real one drops it
	task automatic test_register_write();
		set_layout(FMT_16, 2, 2);
		send_word(32'h0000_0064, 1'b0);
		wait_idle();
		apb_write(REG_UNUSED, 32'h5);
		send_word(32'h0000_012C, 1'b0);
		send_word(32'h0000_03E8, 1'b0);
		wait_idle();
		apb_write(REG_SRC_CHANNELS, 32'h2);
		send_word(32'hFFFF_FFFC, 1'b0);
		send_word(32'hFFFF_FFF7, 1'b1);
	endtask

	// receiver holds off while the sender keeps pushing words
	task automatic test_backpressure();
		int k;
		set_layout(FMT_32, 1, 2);
		src_calm = 1'b1;
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		for (k = 0; k < 40; k++)
			send_word(pick_sample(), 1'($urandom_range(0, 1)));
		src_calm = 1'b0;
	endtask

	// sender pauses between frames until every due word is back
	task automatic test_drain_pause();
		int f;
		int k;
		set_layout(FMT_24, 4, 2);
		for (f = 0; f < 6; f++) begin
			for (k = 0; k < 4; k++)
				send_word(pick_sample(), k == 3);
			src_valid <= 1'b0;
			@(posedge clk);
			while (downmix_due.size() != 0) @(posedge clk);
		end
	endtask

	task automatic test_random_layouts();
		int phase;
		int sent;
		int flen;
		int k;
		int src;
		int dest;
		logic fin;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					src = 1;
					dest = 2;
				end
				2, 3: begin
					src = 2;
					dest = 1;
				end
				8: begin
					src = $urandom_range(0, 15);
					dest = $urandom_range(0, 15);
				end
				default: begin
					src = $urandom_range(2, MAX_CHANNELS);
					dest = 2;
				end
			endcase
			set_layout(2'($urandom_range(0, 3)), src, dest);
			src_calm = ($urandom_range(0, 3) == 0);
			rx_calm  = ($urandom_range(0, 3) == 0);
			flen = frame_len();
			sent = 0;
			while (sent < PHASE_WORDS) begin
				if ($urandom_range(0, 9) == 0) begin
					send_word($urandom, 1'($urandom_range(0, 1)));
					sent++;
				end else begin
					for (k = 0; k < flen; k++) begin
						if (k == flen - 1)
							fin = ($urandom_range(0, 3) == 0);
						else
							fin = ($urandom_range(0, 29) == 0);
						send_word(pick_sample(), fin);
						sent++;
					end
				end
			end
		end
		src_calm = 1'b0;
		rx_calm  = 1'b0;
	endtask

	// receiver stall: random bursts, or one long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			dst_stall  <= 1'b0;
			hold_left  <= 0;
			stall_left <= 0;
		end else if (hold_go) begin
			hold_left <= LONG_HOLD;
			dst_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			dst_stall <= (hold_left != 1);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			dst_stall  <= (stall_left != 1);
		end else if (rx_calm) begin
			dst_stall <= 1'b0;
		end else begin
			rx_gap = pick_gap();
			stall_left <= rx_gap;
			dst_stall  <= (rx_gap != 0);
		end
	end

	task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		fails++;
	endtask

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (downmix_due.size() == 0) begin
				report("unexpected word", 32'h0, dst_word.sample_out);
			end else begin
				due_word = downmix_due.pop_front();
				if (dst_word.sample_out !== due_word.sample_out)
					report("sample_out", due_word.sample_out, dst_word.sample_out);
				if (dst_word.run_last !== due_word.run_last)
					report("run_last", 32'(due_word.run_last), 32'(dst_word.run_last));
				if (dst_word.bad_layout !== due_word.bad_layout)
					report("bad_layout", 32'(due_word.bad_layout),
					       32'(dst_word.bad_layout));
				if (dst_word.buffer_end !== due_word.buffer_end)
					report("buffer_end", 32'(due_word.buffer_end),
					       32'(dst_word.buffer_end));
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_layout();
		test_mono_to_stereo();
		test_stereo_to_mono();
		test_widest_frame();
		test_unsupported();
		test_register_write();
		test_backpressure();
		test_drain_pause();
		test_random_layouts();
		wait_idle();
		if (fails == 0 && downmix_due.size() == 0)
			$display("tb_pcm_channel_downmix OK");
		else
			$display("tb_pcm_channel_downmix NOT OK");
		$finish;
	end

endmodule
